[src/lrau_pkg.sv]
// ----------------------------------------------------------------------------
// lrau_pkg
// Shared types, constants and coefficient tables for the log2 rational unit.
// ----------------------------------------------------------------------------
package lrau_pkg;

    localparam int          QMAX  = 55;
    localparam logic [63:0] DEC18 = 64'd1000000000000000000;

    typedef struct packed {
        logic               bad;
        logic signed [10:0] ipart;
        logic        [63:0] t;
        logic        [63:0] num;
        logic        [63:0] den;
    } t_hrn;

    typedef struct packed {
        logic               bad;
        logic signed [10:0] ipart;
        logic               neg;
        logic               dz;
        logic        [1:0]  mlo;
        logic        [63:0] den;
        logic        [63:0] rem;
        logic   [QMAX-1:0]  q;
    } t_div;

    function automatic logic [63:0] coef_q58(input logic neg, input logic [7:0] whole,
                                             input logic [63:0] dec);
        logic [63:0] r;
        logic [63:0] q;
        r = dec;
        q = '0;
        for (int i = 0; i < 59; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC18) begin
                r = r - DEC18;
                q = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        q = q + ({56'd0, whole} << 58);
        return neg ? (~q + 64'd1) : q;
    endfunction

    function automatic logic [63:0] num_coef(input int k);
        logic [63:0] c;
        case (k)
            0: c = coef_q58(1'b1, 8'd0,  64'd402889371700189292);
            1: c = coef_q58(1'b1, 8'd0,  64'd289453420280495366);
            2: c = coef_q58(1'b0, 8'd4,  64'd35553382566547498);
            3: c = coef_q58(1'b0, 8'd10, 64'd886133709635736011);
            4: c = coef_q58(1'b0, 8'd11, 64'd844793301542853925);
            5: c = coef_q58(1'b0, 8'd6,  64'd390773726336062666);
            6: c = coef_q58(1'b0, 8'd1,  64'd693325770306826517);
            7: c = coef_q58(1'b0, 8'd0,  64'd189886910572759360);
            default: c = coef_q58(1'b0, 8'd0, 64'd5764311993194937);
        endcase
        return c;
    endfunction

    function automatic logic [63:0] den_coef(input int k);
        logic [63:0] c;
        case (k)
            0: c = coef_q58(1'b0, 8'd0,  64'd970730048249223931);
            1: c = coef_q58(1'b0, 8'd5,  64'd196502306970812057);
            2: c = coef_q58(1'b0, 8'd11, 64'd361730370081149388);
            3: c = coef_q58(1'b0, 8'd13, 64'd39270491740174052);
            4: c = coef_q58(1'b0, 8'd8,  64'd394943721299391370);
            5: c = coef_q58(1'b0, 8'd2,  64'd997996483630437581);
            6: c = coef_q58(1'b0, 8'd0,  64'd547364207571883088);
            7: c = coef_q58(1'b0, 8'd0,  64'd41846067504350624);
            default: c = coef_q58(1'b0, 8'd0, 64'd776125057027982);
        endcase
        return c;
    endfunction

endpackage

[src/lrau_horner_cell.sv]
// ----------------------------------------------------------------------------
// lrau_horner_cell
// One Horner step for numerator and denominator: acc*t rounded to Q5.58,
// plus coefficient. Two register stages: partial products, then combine.
// ----------------------------------------------------------------------------
module lrau_horner_cell #(
    parameter logic [63:0] NCOEF = 64'd0,
    parameter logic [63:0] DCOEF = 64'd0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  lrau_pkg::t_hrn i_d,
    output lrau_pkg::t_hrn o_q
);

    typedef struct packed {
        logic               bad;
        logic signed [10:0] ipart;
        logic        [63:0] t;
        logic        [63:0] n00, n01, n10, n11, ncorr;
        logic        [63:0] d00, d01, d10, d11, dcorr;
    } t_mul;

    t_mul           r_m, n_m;
    lrau_pkg::t_hrn r_q, n_q;

    function automatic logic [63:0] combine(input logic [63:0] p00, input logic [63:0] p01,
                                            input logic [63:0] p10, input logic [63:0] p11,
                                            input logic [63:0] corr, input logic [63:0] c);
        logic [127:0] s;
        s = {p11, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0}
            - {corr, 64'd0} + (128'd1 << 57);
        return s[121:58] + c;
    endfunction

    always_comb begin
        n_m.bad   = i_d.bad;
        n_m.ipart = i_d.ipart;
        n_m.t     = i_d.t;
        n_m.n00   = {32'd0, i_d.num[31:0]}  * {32'd0, i_d.t[31:0]};
        n_m.n01   = {32'd0, i_d.num[31:0]}  * {32'd0, i_d.t[63:32]};
        n_m.n10   = {32'd0, i_d.num[63:32]} * {32'd0, i_d.t[31:0]};
        n_m.n11   = {32'd0, i_d.num[63:32]} * {32'd0, i_d.t[63:32]};
        n_m.ncorr = (i_d.num[63] ? i_d.t : 64'd0) + (i_d.t[63] ? i_d.num : 64'd0);
        n_m.d00   = {32'd0, i_d.den[31:0]}  * {32'd0, i_d.t[31:0]};
        n_m.d01   = {32'd0, i_d.den[31:0]}  * {32'd0, i_d.t[63:32]};
        n_m.d10   = {32'd0, i_d.den[63:32]} * {32'd0, i_d.t[31:0]};
        n_m.d11   = {32'd0, i_d.den[63:32]} * {32'd0, i_d.t[63:32]};
        n_m.dcorr = (i_d.den[63] ? i_d.t : 64'd0) + (i_d.t[63] ? i_d.den : 64'd0);
    end

    always_comb begin
        n_q.bad   = r_m.bad;
        n_q.ipart = r_m.ipart;
        n_q.t     = r_m.t;
        n_q.num   = combine(r_m.n00, r_m.n01, r_m.n10, r_m.n11, r_m.ncorr, NCOEF);
        n_q.den   = combine(r_m.d00, r_m.d01, r_m.d10, r_m.d11, r_m.dcorr, DCOEF);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= n_m;
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/lrau_div_cell.sv]
// ----------------------------------------------------------------------------
// lrau_div_cell
// One restoring division step: shift in a dividend bit, trial subtract,
// append one quotient bit.
// ----------------------------------------------------------------------------
module lrau_div_cell #(
    parameter int FRAC_BITS = 48,
    parameter int IDX       = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  lrau_pkg::t_div i_d,
    output lrau_pkg::t_div o_q
);

    lrau_pkg::t_div r_q, n_q;
    logic           dbit;
    logic [64:0]    rs;
    logic [64:0]    diff;
    logic           ge;

    always_comb begin
        if (IDX == FRAC_BITS + 2) begin
            dbit = i_d.mlo[1];
        end else if (IDX == FRAC_BITS + 1) begin
            dbit = i_d.mlo[0];
        end else begin
            dbit = 1'b0;
        end
        rs   = {i_d.rem, dbit};
        diff = rs - {1'b0, i_d.den};
        ge   = !diff[64];
        n_q      = i_d;
        n_q.rem  = ge ? diff[63:0] : rs[63:0];
        n_q.q    = {i_d.q[lrau_pkg::QMAX-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/log2_rational_approx_unit_core.sv]
// ----------------------------------------------------------------------------
// log2_rational_approx_unit_core
// Fixed-point log2 of a normal IEEE-754 double in (0,1] via an 8/8 rational fit.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle; the whole pipeline holds while a result
// waits on the output. Each result passes through one decode stage, eight
// two-stage Horner cells (32x32 partial products, then combine), one divider
// set-up stage, FRAC_BITS+3 one-bit divider cells and an output stage.
// Rejected arguments return zero with out_of_range set.
// ----------------------------------------------------------------------------
module log2_rational_approx_unit_core #(
    parameter int FRAC_BITS = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [63:0]        i_value_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [58:0] o_log2_result,
    output logic               o_out_of_range
);

    localparam int QB  = FRAC_BITS + 3;
    localparam int LAT = QB + 19;

    logic           en;
    logic [LAT-1:0] r_vld;

    lrau_pkg::t_hrn r_s0, n_s0;
    lrau_pkg::t_hrn hc [0:8];
    lrau_pkg::t_div r_dp, n_dp;
    lrau_pkg::t_div dc [0:QB];

    logic signed [58:0] r_res, n_res;
    logic               r_oor, n_oor;

    logic [10:0] bexp;
    logic [51:0] frac;

    assign en         = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_comb begin
        bexp      = i_value_bits[62:52];
        frac      = i_value_bits[51:0];
        n_s0.bad  = i_value_bits[63] || (bexp == 11'd0) || (bexp > 11'd1023)
                    || ((bexp == 11'd1023) && (frac != 52'd0));
        n_s0.ipart = bexp - 11'd1022;
        n_s0.t     = ({12'd0, frac} - (64'd1 << 51)) << 5;
        n_s0.num   = lrau_pkg::num_coef(8);
        n_s0.den   = lrau_pkg::den_coef(8);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign hc[0] = r_s0;

    for (genvar g = 0; g < 8; g++) begin : g_hrn
        lrau_horner_cell #(
            .NCOEF (lrau_pkg::num_coef(7 - g)),
            .DCOEF (lrau_pkg::den_coef(7 - g))
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (hc[g]),
            .o_q   (hc[g+1])
        );
    end

    always_comb begin
        logic [63:0] mag;
        n_dp.bad   = hc[8].bad;
        n_dp.ipart = hc[8].ipart;
        n_dp.neg   = hc[8].num[63];
        mag        = hc[8].num[63] ? (~hc[8].num + 64'd1) : hc[8].num;
        n_dp.dz    = (hc[8].den == 64'd0) || hc[8].den[63];
        n_dp.mlo   = mag[1:0];
        n_dp.den   = hc[8].den;
        n_dp.rem   = mag >> 2;
        n_dp.q     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp <= n_dp;
        end
    end

    assign dc[0] = r_dp;

    for (genvar g = 0; g < QB; g++) begin : g_div
        lrau_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .IDX       (QB - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (dc[g]),
            .o_q   (dc[g+1])
        );
    end

    always_comb begin
        logic [QB-1:0]      qr;
        logic [63:0]        qs;
        logic [63:0]        sum;
        logic signed [63:0] ssum;
        qr   = (dc[QB].q[QB-1:0] + QB'(1)) >> 1;
        if (dc[QB].dz) begin
            qs = 64'd0;
        end else if (dc[QB].neg) begin
            qs = ~(64'(qr)) + 64'd1;
        end else begin
            qs = 64'(qr);
        end
        sum  = (64'(dc[QB].ipart) << FRAC_BITS) + qs;
        ssum = $signed(sum);
        n_oor = dc[QB].bad;
        if (dc[QB].bad || !sum[63]) begin
            n_res = '0;
        end else if (ssum < -(64'sd1 <<< 58)) begin
            n_res = {1'b1, 58'd0};
        end else begin
            n_res = $signed(sum[58:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_oor <= n_oor;
        end
    end

    assign o_out_valid    = r_vld[LAT-1];
    assign o_log2_result  = r_res;
    assign o_out_of_range = r_oor;

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_log2_result == '0))
        else $error("rejected argument with non-zero result");

    a_non_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_log2_result[58] || (o_log2_result == '0)))
        else $error("positive log2 result");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready disagrees with output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_log2_result)
                                            && $stable(o_out_of_range)))
        else $error("stalled result changed");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the fixed-point log2 unit. Decodes each accepted double,
// forms the rational fit in Q5.58, and checks each result transaction in
// order, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 48;
    localparam int N_RANDOM     = 630;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = FRAC_BITS + 40;

    typedef struct packed {
        logic signed [58:0] log2_result;
        logic               out_of_range;
    } t_log2_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [63:0]        i_value_bits = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [58:0] o_log2_result;
    logic               o_out_of_range;

    logic [63:0] arg_queue[$];
    t_log2_res   log2_expected[$];
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_rejected = 0;
    int          idle_cycles = 0;
    logic        in_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          run_left = 0;

    log2_rational_approx_unit_core #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Q5.58 coefficient from a decimal with 18 places
    function automatic logic [63:0] fit_coef(input logic neg, input logic [7:0] whole,
                                             input logic [63:0] dec);
        logic [127:0] q;
        q = ({64'd0, dec} << 59) / 128'd1000000000000000000;
        q = (q + 128'd1) >> 1;
        q = q + ({120'd0, whole} << 58);
        return neg ? (~q[63:0] + 64'd1) : q[63:0];
    endfunction

    function automatic logic [63:0] num_fit(input int k);
        case (k)
            0: return fit_coef(1'b1, 8'd0,  64'd402889371700189292);
            1: return fit_coef(1'b1, 8'd0,  64'd289453420280495366);
            2: return fit_coef(1'b0, 8'd4,  64'd35553382566547498);
            3: return fit_coef(1'b0, 8'd10, 64'd886133709635736011);
            4: return fit_coef(1'b0, 8'd11, 64'd844793301542853925);
            5: return fit_coef(1'b0, 8'd6,  64'd390773726336062666);
            6: return fit_coef(1'b0, 8'd1,  64'd693325770306826517);
            7: return fit_coef(1'b0, 8'd0,  64'd189886910572759360);
            default: return fit_coef(1'b0, 8'd0, 64'd5764311993194937);
        endcase
    endfunction

    function automatic logic [63:0] den_fit(input int k);
        case (k)
            0: return fit_coef(1'b0, 8'd0,  64'd970730048249223931);
            1: return fit_coef(1'b0, 8'd5,  64'd196502306970812057);
            2: return fit_coef(1'b0, 8'd11, 64'd361730370081149388);
            3: return fit_coef(1'b0, 8'd13, 64'd39270491740174052);
            4: return fit_coef(1'b0, 8'd8,  64'd394943721299391370);
            5: return fit_coef(1'b0, 8'd2,  64'd997996483630437581);
            6: return fit_coef(1'b0, 8'd0,  64'd547364207571883088);
            7: return fit_coef(1'b0, 8'd0,  64'd41846067504350624);
            default: return fit_coef(1'b0, 8'd0, 64'd776125057027982);
        endcase
    endfunction

    function automatic logic [63:0] q58_mul(input logic [63:0] a, input logic [63:0] b);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        p = (p + (128'sd1 <<< 57)) >>> 58;
        return p[63:0];
    endfunction

    function automatic logic [63:0] eval_poly(input logic is_den, input logic [63:0] t);
        logic [63:0] acc;
        acc = is_den ? den_fit(8) : num_fit(8);
        for (int k = 7; k >= 0; k--)
            acc = q58_mul(acc, t) + (is_den ? den_fit(k) : num_fit(k));
        return acc;
    endfunction

    function automatic logic [63:0] fit_quotient(input logic [63:0] num,
                                                 input logic [63:0] den);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] q;
        logic [63:0]  q64;
        neg = num[63];
        mag = neg ? (~num + 64'd1) : num;
        if (den == 64'd0 || den[63])
            return 64'd0;
        q = ({64'd0, mag} << (FRAC_BITS + 1)) / {64'd0, den};
        q64 = (q[63:0] + 64'd1) >> 1;
        return neg ? (~q64 + 64'd1) : q64;
    endfunction

    function automatic t_log2_res predict_log2(input logic [63:0] bits);
        t_log2_res   r;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [63:0] t;
        logic [63:0] sum;
        bexp = bits[62:52];
        frac = bits[51:0];
        r = '0;
        if (bits[63] || bexp == 11'd0 || bexp > 11'd1023 || (bexp == 11'd1023 && frac != 0)) begin
            r.out_of_range = 1'b1;
            return r;
        end
        t = ({12'd0, frac} - (64'd1 << 51)) << 5;
        sum = (({53'd0, bexp} - 64'd1022) << FRAC_BITS)
              + fit_quotient(eval_poly(1'b0, t), eval_poly(1'b1, t));
        if (!sum[63])
            sum = 64'd0;
        else if (sum < 64'hFC00000000000000)
            sum = 64'hFC00000000000000;
        r.log2_result = sum[58:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_log2_res got;
        t_log2_res exp_r;
        in_fire <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                log2_expected.push_back(predict_log2(i_value_bits));
            if (o_out_valid && i_out_ready) begin
                got.log2_result = o_log2_result;
                got.out_of_range = o_out_of_range;
                if (log2_expected.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, got.log2_result,
                             got.out_of_range);
                    n_errors++;
                end else begin
                    exp_r = log2_expected.pop_front();
                    n_checked++;
                    if (exp_r.out_of_range)
                        n_rejected++;
                    if (got.log2_result !== exp_r.log2_result) begin
                        $display("%0t: log2_result expected %h actual %h", $time,
                                 exp_r.log2_result, got.log2_result);
                        n_errors++;
                    end
                    if (got.out_of_range !== exp_r.out_of_range) begin
                        $display("%0t: out_of_range expected %b actual %b", $time,
                                 exp_r.out_of_range, got.out_of_range);
                        n_errors++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0 || arg_queue.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                i_in_valid <= 1'b1;
                i_value_bits <= arg_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver: own stall pattern
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (run_left > 0) begin
                i_out_ready <= 1'b1;
                run_left <= run_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                run_left <= $urandom_range(0, 60);
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
        end
    end

    initial begin
        logic [63:0] v;
        arg_queue.push_back(64'h3FF0000000000000);   // one
        arg_queue.push_back(64'h3FE0000000000000);   // half
        arg_queue.push_back(64'h3FE8000000000000);   // t = 0
        arg_queue.push_back(64'h3FEFFFFFFFFFFFFF);   // just below one
        arg_queue.push_back(64'h0010000000000000);   // smallest normal
        arg_queue.push_back(64'h001FFFFFFFFFFFFF);
        arg_queue.push_back(64'h3CA0000000000000);
        arg_queue.push_back(64'h0000000000000000);   // zero
        arg_queue.push_back(64'h8000000000000000);   // negative zero
        arg_queue.push_back(64'h0000000000000001);   // subnormal
        arg_queue.push_back(64'h000FFFFFFFFFFFFF);
        arg_queue.push_back(64'hBFE0000000000000);   // negative
        arg_queue.push_back(64'h3FF0000000000001);   // above one
        arg_queue.push_back(64'h7FF0000000000000);   // infinity
        arg_queue.push_back(64'h7FF8000000000000);   // NaN
        arg_queue.push_back(64'h7FEFFFFFFFFFFFFF);
        arg_queue.push_back(64'hFFFFFFFFFFFFFFFF);
        arg_queue.push_back(64'h3FE0000000000001);
        arg_queue.push_back(64'h3FD5555555555555);
        for (int i = 0; i < N_RANDOM; i++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0, 1: ;
                2: v = {1'b0, 11'd1022, v[51:0]};
                3: v = {1'b0, 11'd1023, 52'd0};
                default: v = {1'b0, 11'($urandom_range(1, 1022)), v[51:0]};
            endcase
            arg_queue.push_back(v);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (arg_queue.size() == 0 && !i_in_valid);
        wait (log2_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results, %0d of them rejected arguments,", n_checked, n_rejected);
        $display("under random sender gaps and receiver stalls.");
        if (n_errors == 0 && log2_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
